FILE: rtl/addressable_led_chain_driver_assert.svh
`ifndef ADDRESSABLE_LED_CHAIN_DRIVER_ASSERT_SVH
`define ADDRESSABLE_LED_CHAIN_DRIVER_ASSERT_SVH

// condition holds on every edge out of reset
`define ALDC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent on the same edge
`define ALDC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: rtl/aldc_pkg.sv
`default_nettype none

package aldc_pkg;

   localparam int PIXEL_COUNT = 64;
   localparam int IDX_W       = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
   localparam int POS_W       = 8;
   localparam int COLOR_W     = 8;
   localparam int PIXEL_W     = 3 * COLOR_W;
   localparam int BIT_POS_W   = 5;
   localparam int TICK_W      = 16;
   localparam int PULSE_W     = 10;
   localparam int CMD_W       = 3;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int SCALE_STEPS = COLOR_W;
   localparam int STEP_W      = $clog2(SCALE_STEPS);
   localparam int PROD_W      = 2 * COLOR_W;

   localparam logic [COLOR_W-1:0] BRIGHTNESS_RST = 8'd255;
   localparam logic [PULSE_W-1:0] ZERO_HIGH_RST  = 10'd54;
   localparam logic [PULSE_W-1:0] ONE_HIGH_RST   = 10'd126;
   localparam logic [PULSE_W-1:0] BIT_LOW_RST    = 10'd144;
   localparam logic [TICK_W-1:0]  LATCH_LOW_RST  = 16'd10800;

   typedef enum logic [CMD_W-1:0] {
      CMD_SET   = 3'd0,
      CMD_CLEAR = 3'd1,
      CMD_READ  = 3'd2,
      CMD_START = 3'd3,
      CMD_TICK  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      PH_HIGH  = 2'd0,
      PH_LOW   = 2'd1,
      PH_LATCH = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_READ  = 2'd1,
      ST_FETCH = 2'd2,
      ST_SCALE = 2'd3
   } state_type;

   typedef enum logic [2:0] {
      REG_BRIGHTNESS = 3'd0,
      REG_ZERO_HIGH  = 3'd1,
      REG_ONE_HIGH   = 3'd2,
      REG_BIT_LOW    = 3'd3,
      REG_LATCH_LOW  = 3'd4
   } reg_type;

   typedef struct packed {
      logic write;
      logic clear;
      logic read;
   } store_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/aldc_if.sv
`default_nettype none

interface aldc_req_if;
   logic                          valid;
   logic                          ready;
   logic [aldc_pkg::CMD_W-1:0]    command;
   logic [aldc_pkg::POS_W-1:0]    pixel_index;
   logic [aldc_pkg::COLOR_W-1:0]  red_in;
   logic [aldc_pkg::COLOR_W-1:0]  green_in;
   logic [aldc_pkg::COLOR_W-1:0]  blue_in;

   modport source (output valid, command, pixel_index, red_in, green_in, blue_in,
                   input ready);
   modport sink   (input valid, command, pixel_index, red_in, green_in, blue_in,
                   output ready);
endinterface

interface aldc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          line_level;
   logic                          busy_res;
   logic [aldc_pkg::COLOR_W-1:0]  red_out;
   logic [aldc_pkg::COLOR_W-1:0]  green_out;
   logic [aldc_pkg::COLOR_W-1:0]  blue_out;

   modport source (output valid, line_level, busy_res, red_out, green_out, blue_out,
                   input ready);
   modport sink   (input valid, line_level, busy_res, red_out, green_out, blue_out,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/aldc_store.sv
`default_nettype none

module aldc_store (
   input  logic                             clock,
   input  logic                             reset,
   input  aldc_pkg::store_ctl_type          ctl,
   input  logic [aldc_pkg::IDX_W-1:0]       wr_addr,
   input  logic [aldc_pkg::PIXEL_W-1:0]     wr_data,
   input  logic [aldc_pkg::IDX_W-1:0]       rd_addr,
   output logic [aldc_pkg::PIXEL_W-1:0]     rd_data
);

   logic [aldc_pkg::PIXEL_W-1:0]     pixel_mem [aldc_pkg::PIXEL_COUNT];
   logic [aldc_pkg::PIXEL_COUNT-1:0] valid_ff;
   logic [aldc_pkg::PIXEL_COUNT-1:0] valid_in;
   logic [aldc_pkg::PIXEL_W-1:0]     rd_data_ff;
   logic                             rd_hit_ff;

   // entry without valid bit reads as zero
   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = '0;
      end else if (ctl.write) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.write) begin
         pixel_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.read) begin
         rd_data_ff <= pixel_mem[rd_addr];
         rd_hit_ff  <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_hit_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

FILE: rtl/aldc_scale.sv
`default_nettype none

module aldc_scale (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [aldc_pkg::COLOR_W-1:0]  brightness,
   input  logic [aldc_pkg::PIXEL_W-1:0]  pixel,
   output logic                          done,
   output logic [aldc_pkg::PIXEL_W-1:0]  grb
);

   logic                                          busy_ff;
   logic                                          done_ff;
   logic [aldc_pkg::STEP_W-1:0]                   step_ff;
   logic [aldc_pkg::COLOR_W-1:0]                  bright_ff;
   logic [2:0][aldc_pkg::COLOR_W-1:0]             color_ff;
   logic [2:0][aldc_pkg::PROD_W-1:0]              acc_ff;
   logic [2:0][aldc_pkg::PROD_W-1:0]              acc_in;
   logic                                          last_step;

   assign last_step = (step_ff == aldc_pkg::STEP_W'(aldc_pkg::SCALE_STEPS - 1));

   // one brightness bit per cycle, MSB first; lanes 0, 1, 2 are blue, green, red
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         acc_in[l] = {acc_ff[l][aldc_pkg::PROD_W-2:0], 1'b0}
                   + (bright_ff[aldc_pkg::COLOR_W-1]
                      ? {aldc_pkg::COLOR_W'(0), color_ff[l]}
                      : aldc_pkg::PROD_W'(0));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= busy_ff && last_step;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + aldc_pkg::STEP_W'(1);
            if (last_step) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff    <= '0;
         bright_ff <= brightness;
         color_ff  <= pixel;
      end else if (busy_ff) begin
         acc_ff    <= acc_in;
         bright_ff <= {bright_ff[aldc_pkg::COLOR_W-2:0], 1'b0};
      end
   end

   assign done = done_ff;
   assign grb  = {acc_ff[1][aldc_pkg::PROD_W-1:aldc_pkg::COLOR_W],
                  acc_ff[2][aldc_pkg::PROD_W-1:aldc_pkg::COLOR_W],
                  acc_ff[0][aldc_pkg::PROD_W-1:aldc_pkg::COLOR_W]};

endmodule

`default_nettype wire

FILE: rtl/addressable_led_chain_driver.sv
// Serial pixel line driver. Each request carries one command (set pixel, clear all,
// read pixel, start frame, tick) and yields exactly one response with the line level,
// the busy flag and, for a read, the stored colour. Only tick requests advance the
// waveform, so a caller drives one tick per time unit. Set, clear, tick and ignored
// commands are answered straight from the idle state; a read passes through a read
// state for the registered read port of the pixel store; a start, or a tick that
// moves on to the next pixel, goes through a store read and the 8-step bit-serial
// brightness multiply. The store is zero after reset through per-entry valid bits,
// with no clearing pass. A pending response admits a request only as it is taken.
`default_nettype none
`include "addressable_led_chain_driver_assert.svh"

module addressable_led_chain_driver (
   input  logic                                clock,
   input  logic                                reset,
   aldc_req_if.sink                            req_chan,
   aldc_rsp_if.source                          rsp_chan,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [aldc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [aldc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [aldc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   // configuration
   logic [aldc_pkg::COLOR_W-1:0]  brightness_ff;
   logic [aldc_pkg::PULSE_W-1:0]  zero_high_ff;
   logic [aldc_pkg::PULSE_W-1:0]  one_high_ff;
   logic [aldc_pkg::PULSE_W-1:0]  bit_low_ff;
   logic [aldc_pkg::TICK_W-1:0]   latch_low_ff;
   logic                          csr_write;
   aldc_pkg::reg_type             csr_index;

   // control and frame state
   aldc_pkg::state_type           state_ff, state_in;
   logic                          sending_ff, sending_in;
   logic [aldc_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic [aldc_pkg::BIT_POS_W-1:0] bit_ff, bit_in;
   aldc_pkg::phase_type           phase_ff, phase_in;
   logic [aldc_pkg::TICK_W-1:0]   ticks_ff, ticks_in;
   logic [aldc_pkg::PIXEL_W-1:0]  shift_ff, shift_in;

   logic [aldc_pkg::TICK_W-1:0]   ticks_inc;
   logic [aldc_pkg::TICK_W-1:0]   dur;
   logic [aldc_pkg::BIT_POS_W-1:0] bit_inc;
   logic [aldc_pkg::POS_W-1:0]    pos_inc;
   logic                          need_load;
   logic [aldc_pkg::POS_W-1:0]    load_pos;

   // request side
   aldc_pkg::cmd_type             cmd;
   logic                          req_ready;
   logic                          req_fire;
   logic                          idx_in_range;
   logic                          read_in_range_ff;

   // store and scaler
   aldc_pkg::store_ctl_type       store_ctl;
   logic [aldc_pkg::IDX_W-1:0]    store_rd_addr;
   logic [aldc_pkg::PIXEL_W-1:0]  store_rd_data;
   logic                          scale_start;
   logic                          scale_done;
   logic [aldc_pkg::PIXEL_W-1:0]  scale_grb;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_load;
   logic                          rsp_line_ff, rsp_line_in;
   logic                          rsp_busy_ff, rsp_busy_in;
   logic [aldc_pkg::PIXEL_W-1:0]  rsp_color_ff, rsp_color_in;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = aldc_pkg::reg_type'(paddr[aldc_pkg::CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= aldc_pkg::BRIGHTNESS_RST;
         zero_high_ff  <= aldc_pkg::ZERO_HIGH_RST;
         one_high_ff   <= aldc_pkg::ONE_HIGH_RST;
         bit_low_ff    <= aldc_pkg::BIT_LOW_RST;
         latch_low_ff  <= aldc_pkg::LATCH_LOW_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            aldc_pkg::REG_BRIGHTNESS: brightness_ff <= pwdata[aldc_pkg::COLOR_W-1:0];
            aldc_pkg::REG_ZERO_HIGH:  zero_high_ff  <= pwdata[aldc_pkg::PULSE_W-1:0];
            aldc_pkg::REG_ONE_HIGH:   one_high_ff   <= pwdata[aldc_pkg::PULSE_W-1:0];
            aldc_pkg::REG_BIT_LOW:    bit_low_ff    <= pwdata[aldc_pkg::PULSE_W-1:0];
            aldc_pkg::REG_LATCH_LOW:  latch_low_ff  <= pwdata[aldc_pkg::TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         aldc_pkg::REG_BRIGHTNESS: prdata = aldc_pkg::CSR_DATA_W'(brightness_ff);
         aldc_pkg::REG_ZERO_HIGH:  prdata = aldc_pkg::CSR_DATA_W'(zero_high_ff);
         aldc_pkg::REG_ONE_HIGH:   prdata = aldc_pkg::CSR_DATA_W'(one_high_ff);
         aldc_pkg::REG_BIT_LOW:    prdata = aldc_pkg::CSR_DATA_W'(bit_low_ff);
         aldc_pkg::REG_LATCH_LOW:  prdata = aldc_pkg::CSR_DATA_W'(latch_low_ff);
         default:                  prdata = '0;
      endcase
   end

   // ---------------- request decode ----------------
   assign cmd          = aldc_pkg::cmd_type'(req_chan.command);
   assign req_ready    = (state_ff == aldc_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = req_ready;
   assign req_fire     = req_chan.valid && req_ready;
   assign idx_in_range = req_chan.pixel_index < aldc_pkg::POS_W'(aldc_pkg::PIXEL_COUNT);

   // ---------------- waveform sequencing ----------------
   always_comb begin
      sending_in = sending_ff;
      pos_in     = pos_ff;
      bit_in     = bit_ff;
      phase_in   = phase_ff;
      ticks_in   = ticks_ff;
      shift_in   = shift_ff;
      need_load  = 1'b0;
      load_pos   = '0;
      ticks_inc  = ticks_ff + aldc_pkg::TICK_W'(1);
      bit_inc    = bit_ff + aldc_pkg::BIT_POS_W'(1);
      pos_inc    = pos_ff + aldc_pkg::POS_W'(1);

      unique case (phase_ff)
         aldc_pkg::PH_HIGH: dur = shift_ff[aldc_pkg::PIXEL_W-1]
                                  ? aldc_pkg::TICK_W'(one_high_ff)
                                  : aldc_pkg::TICK_W'(zero_high_ff);
         aldc_pkg::PH_LOW:  dur = aldc_pkg::TICK_W'(bit_low_ff);
         default:           dur = latch_low_ff;
      endcase

      if (req_fire) begin
         unique case (cmd)
            aldc_pkg::CMD_START: begin
               if (!sending_ff) begin
                  sending_in = 1'b1;
                  pos_in     = '0;
                  bit_in     = '0;
                  phase_in   = aldc_pkg::PH_HIGH;
                  ticks_in   = '0;
                  need_load  = 1'b1;
               end
            end
            aldc_pkg::CMD_TICK: begin
               if (sending_ff) begin
                  if (ticks_inc < dur) begin
                     ticks_in = ticks_inc;
                  end else begin
                     ticks_in = '0;
                     unique case (phase_ff)
                        aldc_pkg::PH_HIGH: phase_in = aldc_pkg::PH_LOW;
                        aldc_pkg::PH_LOW: begin
                           shift_in = {shift_ff[aldc_pkg::PIXEL_W-2:0], 1'b0};
                           phase_in = aldc_pkg::PH_HIGH;
                           if (bit_inc == aldc_pkg::BIT_POS_W'(aldc_pkg::PIXEL_W)) begin
                              bit_in = '0;
                              pos_in = pos_inc;
                              if (pos_inc >= aldc_pkg::POS_W'(aldc_pkg::PIXEL_COUNT)) begin
                                 phase_in = aldc_pkg::PH_LATCH;
                              end else begin
                                 need_load = 1'b1;
                                 load_pos  = pos_inc;
                              end
                           end else begin
                              bit_in = bit_inc;
                           end
                        end
                        default: begin
                           sending_in = 1'b0;
                           phase_in   = aldc_pkg::PH_HIGH;
                           pos_in     = '0;
                           bit_in     = '0;
                           shift_in   = '0;
                        end
                     endcase
                  end
               end
            end
            default: ;
         endcase
      end

      if ((state_ff == aldc_pkg::ST_SCALE) && scale_done) begin
         shift_in = scale_grb;
      end
   end

   // ---------------- control FSM ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         aldc_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (need_load) begin
                  state_in = aldc_pkg::ST_FETCH;
               end else if (cmd == aldc_pkg::CMD_READ) begin
                  state_in = aldc_pkg::ST_READ;
               end
            end
         end
         aldc_pkg::ST_READ:  state_in = aldc_pkg::ST_IDLE;
         aldc_pkg::ST_FETCH: state_in = aldc_pkg::ST_SCALE;
         aldc_pkg::ST_SCALE: begin
            if (scale_done) begin
               state_in = aldc_pkg::ST_IDLE;
            end
         end
         default: state_in = aldc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      store_ctl    = '0;
      scale_start  = 1'b0;
      rsp_load     = 1'b0;
      rsp_line_in  = sending_ff && (phase_ff == aldc_pkg::PH_HIGH);
      rsp_busy_in  = sending_ff;
      rsp_color_in = '0;
      unique case (state_ff)
         aldc_pkg::ST_IDLE: begin
            store_ctl.write = req_fire && (cmd == aldc_pkg::CMD_SET) && !sending_ff
                              && idx_in_range;
            store_ctl.clear = req_fire && (cmd == aldc_pkg::CMD_CLEAR) && !sending_ff;
            store_ctl.read  = req_fire && ((cmd == aldc_pkg::CMD_READ) || need_load);
            rsp_load        = req_fire && !need_load && (cmd != aldc_pkg::CMD_READ);
            rsp_line_in     = sending_in && (phase_in == aldc_pkg::PH_HIGH);
            rsp_busy_in     = sending_in;
         end
         aldc_pkg::ST_READ: begin
            rsp_load     = 1'b1;
            rsp_color_in = read_in_range_ff ? store_rd_data : '0;
         end
         aldc_pkg::ST_FETCH: scale_start = 1'b1;
         aldc_pkg::ST_SCALE: rsp_load = scale_done;
         default: ;
      endcase
   end

   assign store_rd_addr = need_load ? load_pos[aldc_pkg::IDX_W-1:0]
                                    : req_chan.pixel_index[aldc_pkg::IDX_W-1:0];

   aldc_store u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (store_ctl),
      .wr_addr (req_chan.pixel_index[aldc_pkg::IDX_W-1:0]),
      .wr_data ({req_chan.red_in, req_chan.green_in, req_chan.blue_in}),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   aldc_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .start      (scale_start),
      .brightness (brightness_ff),
      .pixel      (store_rd_data),
      .done       (scale_done),
      .grb        (scale_grb)
   );

   // ---------------- registers ----------------
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aldc_pkg::ST_IDLE;
         sending_ff   <= 1'b0;
         pos_ff       <= '0;
         bit_ff       <= '0;
         phase_ff     <= aldc_pkg::PH_HIGH;
         ticks_ff     <= '0;
         shift_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sending_ff   <= sending_in;
         pos_ff       <= pos_in;
         bit_ff       <= bit_in;
         phase_ff     <= phase_in;
         ticks_ff     <= ticks_in;
         shift_ff     <= shift_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         read_in_range_ff <= idx_in_range;
      end
      if (rsp_load) begin
         rsp_line_ff  <= rsp_line_in;
         rsp_busy_ff  <= rsp_busy_in;
         rsp_color_ff <= rsp_color_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.line_level = rsp_line_ff;
   assign rsp_chan.busy_res   = rsp_busy_ff;
   assign rsp_chan.red_out    = rsp_color_ff[3*aldc_pkg::COLOR_W-1:2*aldc_pkg::COLOR_W];
   assign rsp_chan.green_out  = rsp_color_ff[2*aldc_pkg::COLOR_W-1:aldc_pkg::COLOR_W];
   assign rsp_chan.blue_out   = rsp_color_ff[aldc_pkg::COLOR_W-1:0];

   // ---------------- assertions ----------------
   `ALDC_ASSERT_ALWAYS(a_bit_pos_range, clock, reset,
      bit_ff < aldc_pkg::BIT_POS_W'(aldc_pkg::PIXEL_W), "bit position past pixel width")
   `ALDC_ASSERT_ALWAYS(a_pixel_pos_range, clock, reset,
      pos_ff <= aldc_pkg::POS_W'(aldc_pkg::PIXEL_COUNT), "pixel position past chain")
   `ALDC_ASSERT_IMPLIES(a_idle_frame_clean, clock, reset, !sending_ff,
      (pos_ff == '0) && (bit_ff == '0) && (phase_ff == aldc_pkg::PH_HIGH),
      "frame counters not cleared while idle")
   `ALDC_ASSERT_IMPLIES(a_latch_drained, clock, reset, phase_ff == aldc_pkg::PH_LATCH,
      (shift_ff == '0) && (bit_ff == '0), "latch gap entered with bits left")
   `ALDC_ASSERT_IMPLIES(a_busy_no_rsp, clock, reset, state_ff != aldc_pkg::ST_IDLE,
      !rsp_valid_ff, "response pending during multi-cycle request")

endmodule

`default_nettype wire

FILE: test/tb_addressable_led_chain_driver.sv
`timescale 1ns / 1ps

module tb_addressable_led_chain_driver;
   import aldc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 24;
   localparam int RANDOM_TARGET  = 700;
   localparam int CMD_MAX        = (1 << CMD_W) - 1;
   localparam int INDEX_MAX      = (1 << POS_W) - 1;
   localparam int REG_SLOTS      = (1 << CSR_ADDR_W) / 4;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [POS_W-1:0]   pixel_index;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } led_request_t;

   typedef struct packed {
      logic               line_level;
      logic               busy;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } led_response_t;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   aldc_req_if req_bus ();
   aldc_rsp_if rsp_bus ();

   addressable_led_chain_driver u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // line predictor state
   logic [PIXEL_W-1:0]  pixel_mem [PIXEL_COUNT];
   logic                frame_active;
   logic [POS_W-1:0]    frame_pixel;
   logic [BIT_POS_W-1:0] frame_bit;
   phase_type           frame_phase;
   logic [TICK_W-1:0]   phase_count;
   logic [PIXEL_W-1:0]  frame_word;

   logic [COLOR_W-1:0]  cfg_brightness;
   logic [PULSE_W-1:0]  cfg_zero_high;
   logic [PULSE_W-1:0]  cfg_one_high;
   logic [PULSE_W-1:0]  cfg_bit_low;
   logic [TICK_W-1:0]   cfg_latch_low;

   led_response_t expected_responses [$];
   led_response_t want;

   int       error_count = 0;
   int       requests_sent = 0;
   int       responses_checked = 0;
   int       frames_finished = 0;
   int       register_writes = 0;
   int       idle_cycles = 0;
   int       stall_left = 0;
   int       pace_mode = 1;
   logic [7:0] pace_timer = '0;
   bit       calm = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [COLOR_W-1:0] dim_color(logic [COLOR_W-1:0] value);
      logic [PROD_W-1:0] product;
      product = value * cfg_brightness;
      return product[PROD_W-1:COLOR_W];
   endfunction

   // pixel loaded for sending: scaled with the brightness in force now, G R B order
   function automatic void load_frame_word(logic [POS_W-1:0] index);
      logic [PIXEL_W-1:0] pixel;
      pixel = pixel_mem[index];
      frame_word = {dim_color(pixel[15:8]), dim_color(pixel[23:16]), dim_color(pixel[7:0])};
   endfunction

   function automatic void tick_waveform();
      logic [TICK_W-1:0] span;
      if (!frame_active) return;
      if (frame_phase == PH_HIGH) begin
         span = frame_word[PIXEL_W-1] ? cfg_one_high : cfg_zero_high;
      end else if (frame_phase == PH_LOW) begin
         span = cfg_bit_low;
      end else begin
         span = cfg_latch_low;
      end
      phase_count = phase_count + 1'b1;
      if (phase_count < span) return;
      phase_count = '0;
      if (frame_phase == PH_HIGH) begin
         frame_phase = PH_LOW;
      end else if (frame_phase == PH_LOW) begin
         frame_word  = frame_word << 1;
         frame_bit   = frame_bit + 1'b1;
         frame_phase = PH_HIGH;
         if (frame_bit >= PIXEL_W) begin
            frame_bit   = '0;
            frame_pixel = frame_pixel + 1'b1;
            if (frame_pixel >= PIXEL_COUNT) frame_phase = PH_LATCH;
            else load_frame_word(frame_pixel);
         end
      end else begin
         frame_active = 1'b0;
         frame_phase  = PH_HIGH;
         frame_pixel  = '0;
         frame_bit    = '0;
         frame_word   = '0;
         frames_finished++;
      end
   endfunction

   function automatic led_response_t apply_led_command(led_request_t rq);
      led_response_t rs;
      logic [PIXEL_W-1:0] fetched;
      fetched = '0;
      case (rq.command)
         CMD_SET: begin
            if (!frame_active && rq.pixel_index < PIXEL_COUNT)
               pixel_mem[rq.pixel_index] = {rq.red, rq.green, rq.blue};
         end
         CMD_CLEAR: begin
            if (!frame_active) foreach (pixel_mem[i]) pixel_mem[i] = '0;
         end
         CMD_READ: begin
            if (rq.pixel_index < PIXEL_COUNT) fetched = pixel_mem[rq.pixel_index];
         end
         CMD_START: begin
            if (!frame_active) begin
               frame_active = 1'b1;
               frame_pixel  = '0;
               frame_bit    = '0;
               frame_phase  = PH_HIGH;
               phase_count  = '0;
               load_frame_word('0);
            end
         end
         CMD_TICK: tick_waveform();
         default: ;
      endcase
      rs.line_level = frame_active && frame_phase == PH_HIGH;
      rs.busy       = frame_active;
      {rs.red, rs.green, rs.blue} = fetched;
      return rs;
   endfunction

   function automatic void reset_predictor();
      foreach (pixel_mem[i]) pixel_mem[i] = '0;
      frame_active   = 1'b0;
      frame_pixel    = '0;
      frame_bit      = '0;
      frame_phase    = PH_HIGH;
      phase_count    = '0;
      frame_word     = '0;
      cfg_brightness = BRIGHTNESS_RST;
      cfg_zero_high  = ZERO_HIGH_RST;
      cfg_one_high   = ONE_HIGH_RST;
      cfg_bit_low    = BIT_LOW_RST;
      cfg_latch_low  = LATCH_LOW_RST;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] register_value(int index);
      logic [CSR_DATA_W-1:0] value;
      value = '0;
      case (index)
         REG_BRIGHTNESS: value = cfg_brightness;
         REG_ZERO_HIGH:  value = cfg_zero_high;
         REG_ONE_HIGH:   value = cfg_one_high;
         REG_BIT_LOW:    value = cfg_bit_low;
         REG_LATCH_LOW:  value = cfg_latch_low;
         default: ;
      endcase
      return value;
   endfunction

   function automatic void compare_field(string name, logic [CSR_DATA_W-1:0] expected,
                                         logic [CSR_DATA_W-1:0] actual);
      if (actual !== expected) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expected, actual);
      end
   endfunction

   function automatic bit want_idle();
      if (calm || pace_mode == 0) return 1'b0;
      return $urandom_range(0, (pace_mode == 1) ? 15 : 3) == 0;
   endfunction

   function automatic logic [POS_W-1:0] pick_index();
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, INDEX_MAX);
      return $urandom_range(0, PIXEL_COUNT - 1);
   endfunction

   task automatic send_request(input logic [CMD_W-1:0] command, input logic [POS_W-1:0] index,
                               input logic [COLOR_W-1:0] red, input logic [COLOR_W-1:0] green,
                               input logic [COLOR_W-1:0] blue);
      led_request_t rq;
      rq = {command, index, red, green, blue};
      if (want_idle()) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.command     <= command;
      req_bus.pixel_index <= index;
      req_bus.red_in      <= red;
      req_bus.green_in    <= green;
      req_bus.blue_in     <= blue;
      do @(posedge clock); while (!req_bus.ready);
      expected_responses.push_back(apply_led_command(rq));
      requests_sent++;
   endtask

   task automatic send_tick();
      send_request(CMD_TICK, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic wait_for_responses();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_responses.size() != 0);
   endtask

   task automatic write_register(input int index, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= index << 2;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (index)
         REG_BRIGHTNESS: cfg_brightness = value[COLOR_W-1:0];
         REG_ZERO_HIGH:  cfg_zero_high  = value[PULSE_W-1:0];
         REG_ONE_HIGH:   cfg_one_high   = value[PULSE_W-1:0];
         REG_BIT_LOW:    cfg_bit_low    = value[PULSE_W-1:0];
         REG_LATCH_LOW:  cfg_latch_low  = value[TICK_W-1:0];
         default: ;
      endcase
      register_writes++;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_register(input int index);
      logic [CSR_DATA_W-1:0] data;
      logic                  done;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= index << 2;
      @(posedge clock);
      penable <= 1'b1;
      do begin
         @(negedge clock);
         data = prdata;
         done = pready;
         @(posedge clock);
      end while (!done);
      compare_field($sformatf("register %0d", index), register_value(index), data);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_timing(input int zero_high, input int one_high, input int bit_low);
      write_register(REG_ZERO_HIGH, zero_high);
      write_register(REG_ONE_HIGH, one_high);
      write_register(REG_BIT_LOW, bit_low);
   endtask

   // reset values, idle ticks, spare commands, reads of untouched pixels
   task automatic test_idle_behavior();
      for (int r = 0; r <= REG_LATCH_LOW; r++) check_register(r);
      send_request(CMD_READ, 0, 8'hFF, 8'hFF, 8'hFF);
      send_request(CMD_READ, PIXEL_COUNT - 1, 0, 0, 0);
      send_tick();
      for (int c = int'(CMD_TICK) + 1; c <= CMD_MAX; c++)
         send_request(c, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic test_pixel_store();
      send_request(CMD_SET, 0, 8'hFF, 8'hFF, 8'hFF);
      send_request(CMD_SET, PIXEL_COUNT - 1, 8'h5A, 8'hA5, 8'h3C);
      send_request(CMD_SET, PIXEL_COUNT, 8'h11, 8'h22, 8'h33);
      send_request(CMD_SET, INDEX_MAX, 8'h80, 8'h01, 8'hFE);
      send_request(CMD_READ, 0, 0, 0, 0);
      send_request(CMD_READ, PIXEL_COUNT - 1, 0, 0, 0);
      send_request(CMD_READ, PIXEL_COUNT, 0, 0, 0);
      send_request(CMD_READ, INDEX_MAX, 0, 0, 0);
      send_request(CMD_CLEAR, 0, 0, 0, 0);
      send_request(CMD_READ, 0, 0, 0, 0);
      send_request(CMD_READ, PIXEL_COUNT - 1, 0, 0, 0);
   endtask

   // one frame under default, longest, zero and short timings, rewritten live
   task automatic test_frame_timing();
      send_request(CMD_SET, 0, 8'h0F, 8'hAA, 8'hF0);
      send_request(CMD_SET, PIXEL_COUNT - 1, 8'hFF, 8'hFF, 8'hFF);
      send_request(CMD_START, 0, 0, 0, 0);
      send_request(CMD_SET, 1, 8'h12, 8'h34, 8'h56);
      send_request(CMD_CLEAR, 0, 0, 0, 0);
      send_request(CMD_START, 0, 0, 0, 0);
      send_request(CMD_READ, 0, 0, 0, 0);
      while (frame_active && frame_bit < 3) send_tick();
      wait_for_responses();
      set_timing((1 << PULSE_W) - 1, (1 << PULSE_W) - 1, (1 << PULSE_W) - 1);
      while (frame_active && frame_bit < 4) send_tick();
      wait_for_responses();
      set_timing(0, 0, 0);
      while (frame_active && frame_pixel < PIXEL_COUNT / 2) send_tick();
      wait_for_responses();
      write_register(REG_BRIGHTNESS, 128);
      set_timing(1, 2, 1);
      while (frame_active && frame_phase != PH_LATCH) send_tick();
      wait_for_responses();
      write_register(REG_LATCH_LOW, (1 << TICK_W) - 1);
      send_request(CMD_START, 0, 0, 0, 0);
      repeat (200) send_tick();
      wait_for_responses();
      write_register(REG_LATCH_LOW, 0);
      while (frame_active) send_tick();
      send_request(CMD_READ, 1, 0, 0, 0);
   endtask

   task automatic test_register_access();
      int w;
      wait_for_responses();
      for (int r = 0; r <= REG_LATCH_LOW; r++) begin
         w = (r == REG_BRIGHTNESS) ? COLOR_W : (r == REG_LATCH_LOW) ? TICK_W : PULSE_W;
         write_register(r, ($urandom << w) | ((1 << w) - 1));
         check_register(r);
         write_register(r, ($urandom << w) | 1);
         check_register(r);
      end
      for (int r = int'(REG_LATCH_LOW) + 1; r < REG_SLOTS; r++) write_register(r, $urandom);
      for (int r = 0; r <= REG_LATCH_LOW; r++) check_register(r);
   endtask

   // well-formed rounds: fill pixels, start, tick to the latch end, with noise throughout
   task automatic test_random_frames();
      int commands_sent;
      int roll;
      commands_sent = 0;
      while (commands_sent < RANDOM_TARGET) begin
         wait_for_responses();
         roll = $urandom_range(0, 3);
         write_register(REG_BRIGHTNESS, (roll == 0) ? 0 : (roll == 1) ? 255 : $urandom);
         set_timing($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
         write_register(REG_LATCH_LOW, $urandom_range(0, 40));
         repeat ($urandom_range(5, 40)) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) send_request(CMD_SET, pick_index(), $urandom, $urandom, $urandom);
            else if (roll < 75) send_request(CMD_READ, pick_index(), $urandom, $urandom, $urandom);
            else if (roll < 90) send_tick();
            else if (roll < 97)
               send_request($urandom_range(0, CMD_MAX), pick_index(), $urandom, $urandom,
                            $urandom);
            else send_request(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
            commands_sent++;
         end
         send_request(CMD_START, $urandom, $urandom, $urandom, $urandom);
         commands_sent++;
         while (frame_active) begin
            roll = $urandom_range(0, 63);
            if (roll == 0) begin
               send_request($urandom_range(0, CMD_MAX), pick_index(), $urandom, $urandom,
                            $urandom);
               commands_sent++;
            end else if (roll == 1 && $urandom_range(0, 19) == 0) begin
               // brightness applies from the next loaded pixel, timing at once
               wait_for_responses();
               write_register(REG_BRIGHTNESS, $urandom);
               write_register($urandom_range(REG_ZERO_HIGH, REG_BIT_LOW), $urandom_range(0, 3));
            end else begin
               send_tick();
            end
         end
      end
   endtask

   task automatic test_back_to_back();
      wait_for_responses();
      calm = 1'b1;
      write_register(REG_BRIGHTNESS, 255);
      set_timing(0, 1, 0);
      write_register(REG_LATCH_LOW, 1);
      for (int i = 0; i < 8; i++) send_request(CMD_SET, i, $urandom, $urandom, $urandom);
      for (int i = 0; i < 8; i++) send_request(CMD_READ, i, $urandom, $urandom, $urandom);
      send_request(CMD_START, 0, 0, 0, 0);
      while (frame_active) send_tick();
   endtask

   always @(posedge clock) begin
      pace_timer <= pace_timer + 1'b1;
      if (pace_timer == '0) pace_mode <= $urandom_range(0, 2);
   end

   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_bus.ready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left    <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (want_idle()) begin
         stall_left    <= $urandom_range(0, 14);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_responses.size() == 0) begin
            error_count++;
            $display("%0t: response with no request outstanding, expected none, actual %0h",
                     $time, {rsp_bus.line_level, rsp_bus.busy_res, rsp_bus.red_out,
                             rsp_bus.green_out, rsp_bus.blue_out});
         end else begin
            want = expected_responses.pop_front();
            compare_field("line_level", want.line_level, rsp_bus.line_level);
            compare_field("busy_res", want.busy, rsp_bus.busy_res);
            compare_field("red_out", want.red, rsp_bus.red_out);
            compare_field("green_out", want.green, rsp_bus.green_out);
            compare_field("blue_out", want.blue, rsp_bus.blue_out);
            responses_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no request or response moved for %0d cycles", $time, idle_cycles);
         $display("tb_addressable_led_chain_driver NOT OK");
         $finish;
      end
   end

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.command     = '0;
      req_bus.pixel_index = '0;
      req_bus.red_in      = '0;
      req_bus.green_in    = '0;
      req_bus.blue_in     = '0;
      rsp_bus.ready       = 1'b0;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      reset_predictor();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_behavior();
      test_pixel_store();
      test_frame_timing();
      test_register_access();
      test_random_frames();
      test_back_to_back();

      wait_for_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_responses.size() != 0) begin
         error_count++;
         $display("%0t: responses missing, expected %0d more, actual 0", $time,
                  expected_responses.size());
      end
      $display("covered: %0d requests, %0d responses checked, %0d frames sent to the latch end",
               requests_sent, responses_checked, frames_finished);
      $display("covered: %0d register writes incl. extremes, zero timings and live rewrites",
               register_writes);
      if (error_count == 0) begin
         $display("tb_addressable_led_chain_driver OK");
      end else begin
         $display("tb_addressable_led_chain_driver NOT OK");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/aldc_pkg.sv
rtl/aldc_if.sv
rtl/aldc_store.sv
rtl/aldc_scale.sv
rtl/addressable_led_chain_driver.sv
test/tb_addressable_led_chain_driver.sv
